>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ist_pkg.sv
`timescale 1ns / 1ps
package ist_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int DEF_CAPACITY = 16;

  // Commands from controller to datapath
  typedef struct packed {
    logic insert;  // place the incoming value into the chain
    logic drop;    // incoming value lost, chain is full
    logic shift;   // move head of chain into the output register
  } ist_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;      // chain holds CAPACITY values
    logic last_one;  // exactly one value left in the chain
  } ist_status_t;

endpackage

>>> hw/rtl/ist_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ist_dpath #(
  parameter int CAPACITY = ist_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ist_pkg::ist_cmd_t                cmd,
  output ist_pkg::ist_status_t             status,
  input  logic signed [ist_pkg::DATA_W-1:0] in_value,
  output logic signed [ist_pkg::DATA_W-1:0] out_value,
  output logic        [ist_pkg::POS_W-1:0]  out_position,
  output logic                             out_end,
  output logic                             out_overflow
);
  import ist_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] val_r   [CAPACITY];
  logic signed [DATA_W-1:0] val_nxt [CAPACITY];
  logic        [POS_W-1:0]  pos_r   [CAPACITY];
  logic        [POS_W-1:0]  pos_nxt [CAPACITY];
  logic        [CAPACITY-1:0] ins;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              dropped_r, dropped_nxt;
  logic [POS_W-1:0]  new_pos;

  logic signed [DATA_W-1:0] out_value_r;
  logic        [POS_W-1:0]  out_position_r;
  logic                     out_end_r;
  logic                     out_overflow_r;

  // arrival position of the incoming value, low bits only
  assign new_pos = POS_W'(fill_r);

  // Insertion chain: a cell takes a new entry when its stored value is
  // strictly greater than the incoming one, or when it is the first free
  // cell. Equal values stay ahead, so ties keep arrival order.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign ins[g] = ((fill_r > FILL_W'(g)) && (val_r[g] > in_value)) ||
                    (fill_r == FILL_W'(g));

    always_comb begin
      val_nxt[g] = val_r[g];
      pos_nxt[g] = pos_r[g];
      if (cmd.shift) begin
        if (g < CAPACITY - 1) begin
          val_nxt[g] = val_r[(g < CAPACITY - 1) ? g + 1 : g];
          pos_nxt[g] = pos_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end else if (cmd.insert && ins[g]) begin
        if (g > 0 && ins[(g > 0) ? g - 1 : g]) begin
          val_nxt[g] = val_r[(g > 0) ? g - 1 : g];
          pos_nxt[g] = pos_r[(g > 0) ? g - 1 : g];
        end else begin
          val_nxt[g] = in_value;
          pos_nxt[g] = new_pos;
        end
      end
    end

    always_ff @(posedge clk) begin
      val_r[g] <= val_nxt[g];
      pos_r[g] <= pos_nxt[g];
    end
  end

  // Fill count and drop flag
  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (cmd.drop) begin
      dropped_nxt = 1'b1;
    end
    if (cmd.shift) begin
      fill_nxt = fill_r - FILL_W'(1);
      if (fill_r == FILL_W'(1)) begin
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Output payload register, loaded from the head of the chain
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      out_value_r    <= val_r[0];
      out_position_r <= pos_r[0];
      out_end_r      <= (fill_r == FILL_W'(1));
      out_overflow_r <= dropped_r;
    end
  end

  assign out_value       = out_value_r;
  assign out_position    = out_position_r;
  assign out_end         = out_end_r;
  assign out_overflow    = out_overflow_r;
  assign status.full     = (fill_r == FILL_W'(CAPACITY));
  assign status.last_one = (fill_r == FILL_W'(1));

  `ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(CAPACITY), "fill count above capacity")
  `ASSERT_ALWAYS(a_shift_nonempty, !cmd.shift || fill_r != '0, "shift from empty chain")
  `ASSERT_ALWAYS(a_insert_room, !cmd.insert || !status.full, "insert into full chain")

endmodule

>>> hw/rtl/ist_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_final_item,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ist_pkg::ist_cmd_t    cmd,
  input  ist_pkg::ist_status_t status
);
  import ist_pkg::*;

  localparam logic [0:0] ST_LOAD = 1'b0;
  localparam logic [0:0] ST_EMIT = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall = (state_r != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: load values until the final one, then drain the chain
  always_comb begin
    state_nxt  = state_r;
    cmd.insert = 1'b0;
    cmd.drop   = 1'b0;
    cmd.shift  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          cmd.insert = !status.full;
          cmd.drop   = status.full;
          if (in_final_item) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.shift = 1'b1;
          if (status.last_one) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Output valid: set on a shift, cleared once the transfer completes
  always_comb begin
    if (cmd.shift) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_final_to_emit, accept && in_final_item, state_r == ST_EMIT, "final item did not start drain")
  `ASSERT_NEXT(a_shift_valid, cmd.shift, out_valid_r, "shifted result not presented")
  `ASSERT_ALWAYS(a_no_shift_when_blocked, !cmd.shift || out_free, "shift overwrote pending result")

endmodule

>>> hw/rtl/index_tagged_sorter_core.sv
`timescale 1ns / 1ps
// Index-tagged sorter.
// Input channel (in_valid / in_stall): one signed 32-bit value per transfer;
// in_final_item marks the last value of a set. Each value is inserted into a
// sorted chain of CAPACITY cells in the cycle it is accepted, so loading runs
// at one value per cycle. Values beyond CAPACITY are dropped and flagged.
// After the final value is accepted, in_stall is held high while the chain
// drains: the controller enters its drain state, then each shift loads the
// head of the chain into the output register, one result per cycle while
// out_stall is low, ascending, each with its arrival position. Equal values
// keep arrival order. out_end_of_run marks the last result; out_overflow_flag
// is set on every result of a set that lost values. The next set may start
// loading as soon as the last result sits in the output register. The drain
// rate is one shift of the chain per cycle. When out_stall is high the output
// register holds its result and the chain waits. Reset (rst_n low, synchronous)
// empties the chain and clears the drop flag and output valid.
module index_tagged_sorter_core #(
  parameter int CAPACITY = ist_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ist_pkg::DATA_W-1:0]  in_sample_value,
  input  logic                               in_final_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ist_pkg::DATA_W-1:0]  out_sorted_value,
  output logic        [ist_pkg::POS_W-1:0]   out_source_position,
  output logic                               out_end_of_run,
  output logic                               out_overflow_flag
);
  import ist_pkg::*;

  ist_cmd_t    cmd;
  ist_status_t status;

  ist_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_item (in_final_item),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .status        (status)
  );

  ist_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_value     (in_sample_value),
    .out_value    (out_sorted_value),
    .out_position (out_source_position),
    .out_end      (out_end_of_run),
    .out_overflow (out_overflow_flag)
  );

endmodule

>>> bench/index_tagged_sorter_core_tb.sv
`timescale 1ns / 1ps
module index_tagged_sorter_core_tb;
  import ist_pkg::*;

  localparam int CAP           = DEF_CAPACITY;
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 2 * CAP + 8;

  // value classes for random sets
  localparam int VAL_FULL   = 0;
  localparam int VAL_NARROW = 1;
  localparam int VAL_CORNER = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    logic                     eor;
    logic                     ovf;
  } rank_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_sample_value = '0;
  logic                     in_final_item = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic [POS_W-1:0]         out_source_position;
  logic                     out_end_of_run;
  logic                     out_overflow_flag;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          errors = 0;

  // predictor state: sorted chain and drop flag of the set being loaded
  logic signed [DATA_W-1:0] chain_val [CAP];
  logic [POS_W-1:0]         chain_pos [CAP];
  int                       chain_fill = 0;
  bit                       chain_dropped = 1'b0;
  rank_t                    pending_ranks [$];

  index_tagged_sorter_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .in_final_item       (in_final_item),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sorted_value    (out_sorted_value),
    .out_source_position (out_source_position),
    .out_end_of_run      (out_end_of_run),
    .out_overflow_flag   (out_overflow_flag)
  );

  always #6 clk = ~clk;

  // insert one accepted value; on the final one, queue the whole sorted set
  function automatic void rank_insert(input logic signed [DATA_W-1:0] v, input logic fin);
    int    k;
    rank_t r;
    if (chain_fill < CAP) begin
      k = chain_fill;
      // ties stay behind earlier arrivals
      while (k > 0 && chain_val[k-1] > v) begin
        chain_val[k] = chain_val[k-1];
        chain_pos[k] = chain_pos[k-1];
        k--;
      end
      chain_val[k] = v;
      chain_pos[k] = POS_W'(chain_fill);
      chain_fill++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (fin) begin
      for (int i = 0; i < chain_fill; i++) begin
        r.value = chain_val[i];
        r.pos   = chain_pos[i];
        r.eor   = (i == chain_fill - 1);
        r.ovf   = chain_dropped;
        pending_ranks.push_back(r);
      end
      chain_fill    = 0;
      chain_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(input int mode);
    int t;
    case (mode)
      VAL_FULL: return $urandom;
      VAL_NARROW: begin
        t = $urandom_range(8);
        return t - 4;
      end
      default: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  // one transfer on the input channel, with random idle cycles in front
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_final_item   <= fin;
    do @(posedge clk); while (in_stall);
    rank_insert(v, fin);
  endtask

  task automatic send_set(input int n, input int mode);
    for (int i = 0; i < n; i++) send_item(pick_value(mode), i == n - 1);
  endtask

  // receiver: random stall, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string field, input longint e, input longint a);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    rank_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d pos %0d",
                 $time, out_sorted_value, out_source_position);
        errors++;
      end else begin
        exp_r = pending_ranks.pop_front();
        if (out_sorted_value !== exp_r.value)
          report_mismatch("sorted_value", exp_r.value, out_sorted_value);
        if (out_source_position !== exp_r.pos)
          report_mismatch("source_position", exp_r.pos, out_source_position);
        if (out_end_of_run !== exp_r.eor)
          report_mismatch("end_of_run", exp_r.eor, out_end_of_run);
        if (out_overflow_flag !== exp_r.ovf)
          report_mismatch("overflow_flag", exp_r.ovf, out_overflow_flag);
      end
    end
  end

  // extremes, ties, single-value set, overflow with the final value dropped
  task automatic test_directed();
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(-32'sd1, 1'b1);
    send_item(32'sd1, 1'b1);
    for (int i = 0; i <= CAP; i++) send_item((i % 5) - 2, i == CAP);
  endtask

  task automatic test_random_phase(input int unsigned s_pct, input int unsigned r_pct,
                                   input int n_items);
    int sent;
    int n;
    sent          = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_items) begin
      n = ($urandom_range(99) < 15) ? $urandom_range(CAP + 4, CAP + 1)
                                    : $urandom_range(CAP, 1);
      send_set(n, $urandom_range(VAL_CORNER));
      sent += n;
    end
  endtask

  // long receiver hold-off while full sets keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    for (int s = 0; s < 3; s++) send_set(CAP, VAL_FULL);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(36, 63, 112);
    test_random_phase(63, 36, 112);
    test_random_phase(0, 0, 112);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[index_tagged_sorter_core] OK");
    else
      $display("[index_tagged_sorter_core] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[index_tagged_sorter_core] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ist_pkg.sv
hw/rtl/ist_dpath.sv
hw/rtl/ist_ctrl.sv
hw/rtl/index_tagged_sorter_core.sv
bench/index_tagged_sorter_core_tb.sv
